[src/smp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// smp_pkg
// Shared types, constants and helpers for the message parser.
// ----------------------------------------------------------------------------
package smp_pkg;

    localparam int LEN_BITS = 16;
    localparam logic [LEN_BITS-1:0] MAX_COUNT = {LEN_BITS{1'b1}};
    localparam logic [31:0] COOKIE = 32'h2112_A442;
    localparam logic [15:0] ERROR_ATTR_TYPE = 16'h0009;
    localparam int HEADER_LEN = 20;
    localparam int TLV_HDR_LEN = 4;
    localparam logic [16:0] START_LIMIT = 17'h1_FFFF;
    localparam logic [16:0] START_RESET = 17'(HEADER_LEN);
    localparam logic [7:0] TOP_BITS_MASK = 8'hC0;
    localparam logic [7:0] METHOD_LO_MASK = 8'h0F;
    localparam logic [7:0] METHOD_MID_MASK = 8'hE0;
    localparam logic [7:0] CLASS_HI_MASK = 8'h01;
    localparam logic [7:0] CLASS_LO_MASK = 8'h10;
    localparam logic [1:0] CLASS_ERROR = 2'd3;
    localparam logic [14:0] ERROR_SCALE = 15'd100;
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [15:0] wanted_type;
    } byte_item_t;

    typedef struct packed {
        logic        well_formed;
        logic [11:0] method;
        logic [1:0]  msg_class;
        logic        attr_found;
        logic [15:0] attr_size;
        logic [15:0] attr_offset;
        logic        error_found;
        logic [14:0] err_code;
        logic [15:0] msg_length;
    } result_item_t;

    // summary of one message handed from front to back
    typedef struct packed {
        logic        ok;
        logic [15:0] type_word;
        logic        found;
        logic [15:0] attr_len;
        logic [15:0] attr_off;
        logic        err_seen;
        logic [7:0]  hundreds;
        logic [7:0]  remainder;
        logic [15:0] count;
    } msg_rec_t;

    function automatic logic [7:0] cookie_byte(input logic [1:0] pos);
        logic [7:0] b;
        case (pos)
            2'd0:    b = COOKIE[31:24];
            2'd1:    b = COOKIE[23:16];
            2'd2:    b = COOKIE[15:8];
            default: b = COOKIE[7:0];
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

[src/smp_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// smp_front
// Per-byte header checks and attribute walk; emits one summary per message.
// ----------------------------------------------------------------------------
module smp_front
    import smp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       take,
    input  wire byte_item_t item,
    output logic            rec_push,
    output msg_rec_t        rec
);

    logic [LEN_BITS-1:0] count_reg, count_next;
    logic                ovf_reg, ovf_next;
    logic [31:0]         hdr_reg, hdr_next;
    logic                cookie_reg, cookie_next;
    logic                top_reg, top_next;
    logic [15:0]         stype_reg, stype_next;
    logic [16:0]         start_reg, start_next;
    logic [31:0]         tlv_reg, tlv_next;
    logic                found_reg, found_next;
    logic [15:0]         alen_reg, alen_next;
    logic [15:0]         aoff_reg, aoff_next;
    logic                eh_reg, eh_next;
    logic [16:0]         eoff_reg, eoff_next;
    logic                ev_reg, ev_next;
    logic [7:0]          hund_reg, hund_next;
    logic [7:0]          rem_reg, rem_next;

    logic [LEN_BITS-1:0] idx;
    logic                at_max;
    logic [16:0]         idx17;
    logic [16:0]         diff;
    logic                in_tlv;
    logic [15:0]         tlv_type;
    logic [15:0]         tlv_len;
    logic [17:0]         off18;
    logic [1:0]          pad;
    logic [17:0]         nxt;
    logic [17:0]         eoff_p2;
    logic [7:0]          b;

    assign idx    = count_reg;
    assign at_max = (count_reg == MAX_COUNT);
    assign b      = item.data_byte;
    assign idx17  = 17'(idx);
    assign diff   = idx17 - start_reg;
    assign in_tlv = (idx17 >= start_reg) && (diff < 17'(TLV_HDR_LEN));

    always_comb
    begin
        count_next  = count_reg;
        ovf_next    = ovf_reg;
        hdr_next    = hdr_reg;
        cookie_next = cookie_reg;
        top_next    = top_reg;
        stype_next  = stype_reg;
        start_next  = start_reg;
        tlv_next    = tlv_reg;
        found_next  = found_reg;
        alen_next   = alen_reg;
        aoff_next   = aoff_reg;
        eh_next     = eh_reg;
        eoff_next   = eoff_reg;
        ev_next     = ev_reg;
        hund_next   = hund_reg;
        rem_next    = rem_reg;
        tlv_type    = tlv_next[31:16];
        tlv_len     = tlv_next[15:0];
        off18       = 18'(start_reg) + 18'(TLV_HDR_LEN);
        pad         = 2'd0 - tlv_len[1:0];
        nxt         = off18 + 18'(tlv_len) + 18'(pad);
        eoff_p2     = 18'(eoff_reg) + 18'd2;
        if (at_max)
        begin
            ovf_next = 1'b1;
        end
        else
        begin
            count_next = count_reg + 1'b1;
            if (idx == '0)
            begin
                stype_next = item.wanted_type;
                if ((b & TOP_BITS_MASK) != 8'd0)
                    top_next = 1'b0;
            end
            if (idx < LEN_BITS'(4))
                hdr_next = {hdr_reg[23:0], b};
            else if (idx < LEN_BITS'(8))
            begin
                if (b != cookie_byte(idx[1:0]))
                    cookie_next = 1'b0;
            end
            if (in_tlv)
            begin
                tlv_next = {tlv_reg[23:0], b};
                tlv_type = tlv_next[31:16];
                tlv_len  = tlv_next[15:0];
                pad      = 2'd0 - tlv_len[1:0];
                nxt      = off18 + 18'(tlv_len) + 18'(pad);
                if (diff[1:0] == 2'd3)
                begin
                    if (!found_reg && tlv_type == stype_reg)
                    begin
                        found_next = 1'b1;
                        alen_next  = tlv_len;
                        aoff_next  = off18[15:0];
                    end
                    if (!eh_reg && tlv_type == ERROR_ATTR_TYPE)
                    begin
                        eh_next   = 1'b1;
                        eoff_next = off18[16:0];
                    end
                    start_next = (nxt > 18'(START_LIMIT)) ? START_LIMIT : nxt[16:0];
                end
            end
            if (eh_reg && !ev_reg)
            begin
                if (18'(idx) == eoff_p2)
                    hund_next = b;
                if (18'(idx) == eoff_p2 + 18'd1)
                begin
                    rem_next = b;
                    ev_next  = 1'b1;
                end
            end
        end
    end

    assign rec_push = take && item.last_byte;

    always_comb
    begin
        rec.ok = !ovf_next && (count_next >= LEN_BITS'(HEADER_LEN)) && top_next
                 && cookie_next
                 && (hdr_next[15:0] == 16'(count_next - LEN_BITS'(HEADER_LEN)));
        rec.type_word  = hdr_next[31:16];
        rec.found      = found_next;
        rec.attr_len   = alen_next;
        rec.attr_off   = aoff_next;
        rec.err_seen   = ev_next;
        rec.hundreds   = hund_next;
        rec.remainder  = rem_next;
        rec.count      = 16'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
            hdr_reg    <= '0;
            cookie_reg <= 1'b1;
            top_reg    <= 1'b1;
            stype_reg  <= '0;
            start_reg  <= START_RESET;
            tlv_reg    <= '0;
            found_reg  <= 1'b0;
            alen_reg   <= '0;
            aoff_reg   <= '0;
            eh_reg     <= 1'b0;
            eoff_reg   <= '0;
            ev_reg     <= 1'b0;
            hund_reg   <= '0;
            rem_reg    <= '0;
        end
        else if (take && item.last_byte)
        begin
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
            hdr_reg    <= '0;
            cookie_reg <= 1'b1;
            top_reg    <= 1'b1;
            stype_reg  <= '0;
            start_reg  <= START_RESET;
            tlv_reg    <= '0;
            found_reg  <= 1'b0;
            alen_reg   <= '0;
            aoff_reg   <= '0;
            eh_reg     <= 1'b0;
            eoff_reg   <= '0;
            ev_reg     <= 1'b0;
            hund_reg   <= '0;
            rem_reg    <= '0;
        end
        else if (take)
        begin
            count_reg  <= count_next;
            ovf_reg    <= ovf_next;
            hdr_reg    <= hdr_next;
            cookie_reg <= cookie_next;
            top_reg    <= top_next;
            stype_reg  <= stype_next;
            start_reg  <= start_next;
            tlv_reg    <= tlv_next;
            found_reg  <= found_next;
            alen_reg   <= alen_next;
            aoff_reg   <= aoff_next;
            eh_reg     <= eh_next;
            eoff_reg   <= eoff_next;
            ev_reg     <= ev_next;
            hund_reg   <= hund_next;
            rem_reg    <= rem_next;
        end
    end

    // value capture never precedes its attribute header
    assert property (@(posedge clk) disable iff (!rst_n) ev_reg |-> eh_reg)
        else $error("error value seen without error header");
    // a match lies past the fixed header
    assert property (@(posedge clk) disable iff (!rst_n)
        found_reg |-> aoff_reg >= 16'(HEADER_LEN + TLV_HDR_LEN))
        else $error("match offset inside fixed header");
    // the walk pointer never moves backward within a message
    assert property (@(posedge clk) disable iff (!rst_n)
        (take && !item.last_byte) |=> start_reg >= $past(start_reg))
        else $error("attribute walk moved backward");

endmodule
`default_nettype wire

[src/smp_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// smp_queue
// Two-entry queue of message summaries between front and back.
// ----------------------------------------------------------------------------
module smp_queue
    import smp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire msg_rec_t push_rec,
    output logic          full,
    input  wire logic     pop,
    output logic          empty,
    output msg_rec_t      head
);

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    msg_rec_t              mem_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]   wr_reg, wr_next;
    logic [PTR_BITS-1:0]   rd_reg, rd_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic                  do_push;
    logic                  do_pop;

    assign full    = (cnt_reg == CNT_BITS'(QUEUE_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
            wr_next = (wr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        if (do_pop)
            rd_next = (rd_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_reg] <= push_rec;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_BITS'(QUEUE_DEPTH))
        else $error("queue count past depth");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0 || cnt_reg == CNT_BITS'(QUEUE_DEPTH)) |-> wr_reg == rd_reg)
        else $error("queue pointers disagree with count");
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && full && !pop) |=> full)
        else $error("queue lost its fill");

endmodule
`default_nettype wire

[src/smp_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// smp_back
// Decodes method, class and error code; holds the result item.
// ----------------------------------------------------------------------------
module smp_back
    import smp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     rec_valid,
    input  wire msg_rec_t rec,
    output logic          rec_pop,
    output logic          result_valid,
    input  wire logic     result_ready,
    output result_item_t  result_item
);

    logic         valid_reg;
    result_item_t item_reg, item_next;
    logic [7:0]   b0;
    logic [7:0]   b1;
    logic [11:0]  method;
    logic [1:0]   cls;
    logic [14:0]  code;

    assign b0 = rec.type_word[15:8];
    assign b1 = rec.type_word[7:0];
    assign method = {b0[5:1], 7'd0} | {4'd0, (b1 & METHOD_MID_MASK) >> 1}
                    | {4'd0, b1 & METHOD_LO_MASK};
    assign cls  = {(b0 & CLASS_HI_MASK) != 8'd0, (b1 & CLASS_LO_MASK) != 8'd0};
    assign code = 15'(rec.hundreds) * ERROR_SCALE + 15'(rec.remainder);

    assign rec_pop = rec_valid && (!valid_reg || result_ready);

    always_comb
    begin
        item_next = '0;
        item_next.msg_length = rec.count;
        if (rec.ok)
        begin
            item_next.well_formed = 1'b1;
            item_next.method      = method;
            item_next.msg_class   = cls;
            if (rec.found)
            begin
                item_next.attr_found  = 1'b1;
                item_next.attr_size   = rec.attr_len;
                item_next.attr_offset = rec.attr_off;
            end
            if (cls == CLASS_ERROR && rec.err_seen)
            begin
                item_next.error_found = 1'b1;
                item_next.err_code    = code;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (rec_pop)
            valid_reg <= 1'b1;
        else if (result_ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (rec_pop)
            item_reg <= item_next;
    end

    assign result_valid = valid_reg;
    assign result_item  = item_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !item_reg.well_formed) |->
        (item_reg.method == 12'd0 && !item_reg.attr_found && !item_reg.error_found))
        else $error("fields set on malformed message");
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && item_reg.error_found) |-> item_reg.msg_class == CLASS_ERROR)
        else $error("error code outside error class");
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !item_reg.attr_found) |->
        (item_reg.attr_size == 16'd0 && item_reg.attr_offset == 16'd0))
        else $error("attribute fields without match");

endmodule
`default_nettype wire

[src/stun_message_parser_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// stun_message_parser_top
// Byte-serial message checker, method/class decoder and attribute finder.
//
// Bytes enter on the byte channel (byte_valid/byte_ready/byte_item), one
// item per cycle while byte_ready is high, with last_byte marking the end
// of a message. One result item per message leaves on the result channel
// (result_valid/result_ready/result_item).
// Throughput: one byte every cycle while byte_ready is high; the per-byte
// checks and the attribute walk are fixed counter and compare logic in the
// front stage. The summary enters the queue on the edge that takes the
// last byte; the back stage then moves it into the output register.
// A two-entry queue of message summaries sits between front and back;
// byte_ready drops only while that queue is full, i.e. while the receiver
// has stalled with several finished messages pending.
// Reset (rst_n low) empties the queue and output and restarts the parser at
// the first byte of a message.
// ----------------------------------------------------------------------------
module stun_message_parser_top
    import smp_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         byte_valid,
    output logic              byte_ready,
    input  wire byte_item_t   byte_item,
    output logic              result_valid,
    input  wire logic         result_ready,
    output result_item_t      result_item
);

    logic     take;
    logic     rec_push;
    msg_rec_t rec;
    logic     q_full;
    logic     q_empty;
    logic     q_pop;
    msg_rec_t q_head;

    assign byte_ready = !q_full;
    assign take       = byte_valid && byte_ready;

    smp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (take),
        .item     (byte_item),
        .rec_push (rec_push),
        .rec      (rec)
    );

    smp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (rec_push),
        .push_rec (rec),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head     (q_head)
    );

    smp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .rec_valid    (!q_empty),
        .rec          (q_head),
        .rec_pop      (q_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_item  (result_item)
    );

endmodule
`default_nettype wire
